### sv/prgba_pkg.sv
`default_nettype none

package prgba_pkg;

    // Longest row the line store holds, and the column width that follows.
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Field and register widths.
    localparam int SAMPLE_W    = 8;
    localparam int MODE_W      = 2;
    localparam int ROW_WIDTH_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH  = 2'd1;

    // Color mode codes.
    localparam logic [MODE_W-1:0] MODE_GRAY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CMYK = 2'd2;

    // Alpha of every pixel.
    localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // What the back has to do with an item.
    typedef enum logic [2:0] {
        OP_STORE0,
        OP_STORE1,
        OP_STORE2,
        OP_GRAY,
        OP_RGB,
        OP_CMYK
    } op_t;

    // One classified item travelling from front to back.
    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
        logic [COL_W-1:0]    col;
        logic                row_end;
    } item_t;

endpackage

`default_nettype wire

### sv/prgba_ram.sv
`default_nettype none

module prgba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/prgba_front.sv
`default_nettype none

module prgba_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [prgba_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [prgba_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                 in_valid,
    input  wire logic                                 queue_full,
    input  wire logic [prgba_pkg::SAMPLE_W-1:0]       sample_byte,
    output      logic                                 push,
    output      prgba_pkg::item_t                     push_item
);

    logic [prgba_pkg::MODE_W-1:0]      color_mode_reg;
    logic [prgba_pkg::ROW_WIDTH_W-1:0] row_width_reg;
    logic [1:0]                        plane_reg;
    logic [1:0]                        plane_next;
    logic [prgba_pkg::COL_W-1:0]       col_reg;
    logic [prgba_pkg::COL_W-1:0]       col_next;
    logic [prgba_pkg::COL_W-1:0]       width_m1;
    logic [1:0]                        last_plane;
    logic [1:0]                        plane;
    logic [prgba_pkg::COL_W-1:0]       col;
    logic                              col_last;

    assign push = in_valid && !queue_full;

    // Last plane index of the current mode; the unused code acts as grayscale.
    always_comb
    begin
        unique case (color_mode_reg)
            prgba_pkg::MODE_RGB:  last_plane = 2'd2;
            prgba_pkg::MODE_CMYK: last_plane = 2'd3;
            default:              last_plane = 2'd0;
        endcase
    end

    // Row width less one, with zero taken as one and large widths saturated.
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            width_m1 = '0;
        end
        else if (32'(row_width_reg) > prgba_pkg::MAX_WIDTH)
        begin
            width_m1 = prgba_pkg::COL_W'(prgba_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            width_m1 = prgba_pkg::COL_W'(row_width_reg - 13'd1);
        end
    end

    // Position of this item within the row.
    always_comb
    begin
        plane    = (plane_reg > last_plane) ? 2'd0 : plane_reg;
        col      = (col_reg > width_m1) ? '0 : col_reg;
        col_last = (col == width_m1);
    end

    // Classify the item for the back.
    always_comb
    begin
        push_item.sample  = sample_byte;
        push_item.col     = col;
        push_item.row_end = (plane == last_plane) && col_last;
        if (plane != last_plane)
        begin
            case (plane)
                2'd0:    push_item.op = prgba_pkg::OP_STORE0;
                2'd1:    push_item.op = prgba_pkg::OP_STORE1;
                default: push_item.op = prgba_pkg::OP_STORE2;
            endcase
        end
        else
        begin
            unique case (color_mode_reg)
                prgba_pkg::MODE_RGB:  push_item.op = prgba_pkg::OP_RGB;
                prgba_pkg::MODE_CMYK: push_item.op = prgba_pkg::OP_CMYK;
                default:              push_item.op = prgba_pkg::OP_GRAY;
            endcase
        end
    end

    // Advance column and plane.
    always_comb
    begin
        if (col_last)
        begin
            col_next   = '0;
            plane_next = (plane == last_plane) ? 2'd0 : plane + 2'd1;
        end
        else
        begin
            col_next   = col + prgba_pkg::COL_W'(1);
            plane_next = plane;
        end
    end

    // Registers and row counters; a write to either real register restarts the row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= prgba_pkg::MODE_GRAY;
            row_width_reg  <= prgba_pkg::ROW_WIDTH_W'(1);
            plane_reg      <= '0;
            col_reg        <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == prgba_pkg::REG_COLOR_MODE)
            begin
                color_mode_reg <= cfg_data[prgba_pkg::MODE_W-1:0];
                plane_reg      <= '0;
                col_reg        <= '0;
            end
            else if (cfg_index == prgba_pkg::REG_ROW_WIDTH)
            begin
                row_width_reg <= cfg_data[prgba_pkg::ROW_WIDTH_W-1:0];
                plane_reg     <= '0;
                col_reg       <= '0;
            end
        end
        else if (push)
        begin
            plane_reg <= plane_next;
            col_reg   <= col_next;
        end
    end

endmodule

`default_nettype wire

### sv/prgba_queue.sv
`default_nettype none

module prgba_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire prgba_pkg::item_t push_item,
    input  wire logic             pop,
    output      prgba_pkg::item_t head_item,
    output      logic             not_empty,
    output      logic             full
);

    prgba_pkg::item_t                 entry_reg [prgba_pkg::QUEUE_DEPTH];
    logic [prgba_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [prgba_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [prgba_pkg::QCNT_W-1:0]     count_reg;
    logic [prgba_pkg::QCNT_W-1:0]     count_next;

    assign head_item = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == prgba_pkg::QCNT_W'(prgba_pkg::QUEUE_DEPTH));

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + prgba_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - prgba_pkg::QCNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == prgba_pkg::QPTR_W'(prgba_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + prgba_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == prgba_pkg::QPTR_W'(prgba_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + prgba_pkg::QPTR_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### sv/prgba_back.sv
`default_nettype none

module prgba_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire prgba_pkg::item_t               head_item,
    input  wire logic                           not_empty,
    output      logic                           pop,
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic [prgba_pkg::SAMPLE_W-1:0] red,
    output      logic [prgba_pkg::SAMPLE_W-1:0] green,
    output      logic [prgba_pkg::SAMPLE_W-1:0] blue,
    output      logic [prgba_pkg::SAMPLE_W-1:0] alpha,
    output      logic [prgba_pkg::COL_W-1:0]    pixel_index,
    output      logic                           row_end
);

    logic                           head_emits;
    logic                           pop_emit;
    logic                           out_ready;
    logic                           b_ready;
    logic                           b_valid_reg;
    prgba_pkg::op_t                 b_op_reg;
    logic [prgba_pkg::SAMPLE_W-1:0] b_sample_reg;
    logic [prgba_pkg::COL_W-1:0]    b_col_reg;
    logic                           b_row_end_reg;
    logic [prgba_pkg::SAMPLE_W-1:0] plane0_rd;
    logic [prgba_pkg::SAMPLE_W-1:0] plane1_rd;
    logic [prgba_pkg::SAMPLE_W-1:0] plane2_rd;
    logic [2*prgba_pkg::SAMPLE_W-1:0] prod_r;
    logic [2*prgba_pkg::SAMPLE_W-1:0] prod_g;
    logic [2*prgba_pkg::SAMPLE_W-1:0] prod_b;
    logic [prgba_pkg::SAMPLE_W-1:0] red_next;
    logic [prgba_pkg::SAMPLE_W-1:0] green_next;
    logic [prgba_pkg::SAMPLE_W-1:0] blue_next;
    logic                           out_valid_reg;

    // Handshake between the read stage and the output register.
    assign out_ready  = !out_valid_reg || !out_stall;
    assign b_ready    = !b_valid_reg || out_ready;
    assign head_emits = (head_item.op == prgba_pkg::OP_GRAY) ||
                        (head_item.op == prgba_pkg::OP_RGB)  ||
                        (head_item.op == prgba_pkg::OP_CMYK);

    // Stores never wait; a pixel waits for room in the read stage.
    assign pop      = not_empty && (!head_emits || b_ready);
    assign pop_emit = pop && head_emits;

    // One line store per kept plane, indexed by column.
    prgba_ram #(
        .WIDTH (prgba_pkg::SAMPLE_W),
        .DEPTH (prgba_pkg::MAX_WIDTH)
    ) u_plane0 (
        .clk     (clk),
        .wr_en   (pop && (head_item.op == prgba_pkg::OP_STORE0)),
        .wr_addr (head_item.col),
        .wr_data (head_item.sample),
        .rd_en   (pop_emit),
        .rd_addr (head_item.col),
        .rd_data (plane0_rd)
    );

    prgba_ram #(
        .WIDTH (prgba_pkg::SAMPLE_W),
        .DEPTH (prgba_pkg::MAX_WIDTH)
    ) u_plane1 (
        .clk     (clk),
        .wr_en   (pop && (head_item.op == prgba_pkg::OP_STORE1)),
        .wr_addr (head_item.col),
        .wr_data (head_item.sample),
        .rd_en   (pop_emit),
        .rd_addr (head_item.col),
        .rd_data (plane1_rd)
    );

    prgba_ram #(
        .WIDTH (prgba_pkg::SAMPLE_W),
        .DEPTH (prgba_pkg::MAX_WIDTH)
    ) u_plane2 (
        .clk     (clk),
        .wr_en   (pop && (head_item.op == prgba_pkg::OP_STORE2)),
        .wr_addr (head_item.col),
        .wr_data (head_item.sample),
        .rd_en   (pop_emit),
        .rd_addr (head_item.col),
        .rd_data (plane2_rd)
    );

    // Read stage: item fields travel alongside the registered store data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= pop_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_emit)
        begin
            b_op_reg      <= head_item.op;
            b_sample_reg  <= head_item.sample;
            b_col_reg     <= head_item.col;
            b_row_end_reg <= head_item.row_end;
        end
    end

    // CMYK products; the upper byte is the scaled component.
    assign prod_r = 16'(plane0_rd) * 16'(b_sample_reg);
    assign prod_g = 16'(plane1_rd) * 16'(b_sample_reg);
    assign prod_b = 16'(plane2_rd) * 16'(b_sample_reg);

    // Pick the color for the pixel's mode.
    always_comb
    begin
        case (b_op_reg)
            prgba_pkg::OP_RGB:
            begin
                red_next   = plane0_rd;
                green_next = plane1_rd;
                blue_next  = b_sample_reg;
            end
            prgba_pkg::OP_CMYK:
            begin
                red_next   = prod_r[2*prgba_pkg::SAMPLE_W-1:prgba_pkg::SAMPLE_W];
                green_next = prod_g[2*prgba_pkg::SAMPLE_W-1:prgba_pkg::SAMPLE_W];
                blue_next  = prod_b[2*prgba_pkg::SAMPLE_W-1:prgba_pkg::SAMPLE_W];
            end
            default:
            begin
                red_next   = b_sample_reg;
                green_next = b_sample_reg;
                blue_next  = b_sample_reg;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && b_valid_reg)
        begin
            red         <= red_next;
            green       <= green_next;
            blue        <= blue_next;
            pixel_index <= b_col_reg;
            row_end     <= b_row_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign alpha     = prgba_pkg::ALPHA_OPAQUE;

endmodule

`default_nettype wire

### sv/planar_row_to_rgba_top.sv
`default_nettype none

// Planar row to RGBA converter. Sample bytes of a row arrive plane after
// plane, one item per clock, and the block gives one packed RGBA pixel for
// each byte of the last plane (every byte in grayscale mode). The front
// counts plane and column and classifies each item; a four-entry queue
// separates it from the back, which writes the first planes into three
// line stores of 4096 bytes, each with one write and one registered read
// port, and reads them back when the last plane arrives. The block takes
// one item per cycle in every mode while the output is not stalled; an
// accepted byte is written into the queue, then its pixel passes the store
// read and the output register, and the multiplies for CMYK sit between
// the store read and the output register.
// The line stores need no clearing after reset.
// Configure color_mode and row_width only while the block is idle; a
// write to the color_mode or row_width register restarts the row.
module planar_row_to_rgba_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [prgba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [prgba_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [prgba_pkg::SAMPLE_W-1:0]    sample_byte,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [prgba_pkg::SAMPLE_W-1:0]    red,
    output      logic [prgba_pkg::SAMPLE_W-1:0]    green,
    output      logic [prgba_pkg::SAMPLE_W-1:0]    blue,
    output      logic [prgba_pkg::SAMPLE_W-1:0]    alpha,
    output      logic [prgba_pkg::COL_W-1:0]       pixel_index,
    output      logic                              row_end
);

    logic             push;
    prgba_pkg::item_t push_item;
    logic             pop;
    prgba_pkg::item_t head_item;
    logic             not_empty;
    logic             full;

    assign in_stall = full;

    prgba_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .queue_full  (full),
        .sample_byte (sample_byte),
        .push        (push),
        .push_item   (push_item)
    );

    prgba_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (not_empty),
        .full      (full)
    );

    prgba_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_item   (head_item),
        .not_empty   (not_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .pixel_index (pixel_index),
        .row_end     (row_end)
    );

endmodule

`default_nettype wire

### sv/prgba_checker.sv
`default_nettype none

module prgba_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [prgba_pkg::SAMPLE_W-1:0]    red,
    input wire logic [prgba_pkg::SAMPLE_W-1:0]    green,
    input wire logic [prgba_pkg::SAMPLE_W-1:0]    blue,
    input wire logic [prgba_pkg::SAMPLE_W-1:0]    alpha,
    input wire logic [prgba_pkg::COL_W-1:0]       pixel_index,
    input wire logic                              row_end
);

    // A stalled pixel stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) &&
            $stable(blue) && $stable(pixel_index) && $stable(row_end))
    else $error("stalled pixel changed or vanished");

    // Every pixel is opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alpha == prgba_pkg::ALPHA_OPAQUE)
    else $error("pixel is not opaque");

    // Reset empties the output register.
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
    else $error("pixel shown during reset");

    // Reset empties the queue, so the input is open right after it.
    assert property (@(posedge clk)
        !rst_n |-> !in_stall)
    else $error("input stalled during reset");

    // The input stalls only after an item has filled the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
    else $error("input stalled with no item taken");

endmodule

bind planar_row_to_rgba_top prgba_checker u_prgba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .pixel_index (pixel_index),
    .row_end     (row_end)
);

`default_nettype wire

### tb/rgba_pixel_checker.sv
`default_nettype none

module rgba_pixel_checker
    import prgba_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [SAMPLE_W-1:0]    sample_byte,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [SAMPLE_W-1:0]    red,
    input  wire logic [SAMPLE_W-1:0]    green,
    input  wire logic [SAMPLE_W-1:0]    blue,
    input  wire logic [SAMPLE_W-1:0]    alpha,
    input  wire logic [COL_W-1:0]       pixel_index,
    input  wire logic                   row_end,
    output int                          fail_count,
    output int                          outstanding
);

    // One finished pixel as it leaves the block.
    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] alpha;
        logic [COL_W-1:0]    col;
        logic                row_last;
    } pixel_t;

    // Shadow copy of the converter state.
    logic [3*SAMPLE_W-1:0]  plane_store [0:MAX_WIDTH-1];
    logic [MODE_W-1:0]      mode_reg;
    logic [ROW_WIDTH_W-1:0] width_reg;
    int                     plane_idx;
    int                     col_idx;

    // Pixels predicted but not yet seen at the output, oldest first.
    pixel_t pixel_q [$];

    // Advance the shadow state by one accepted sample and queue the pixel
    // it finishes, if any.
    task automatic predict_sample(input logic [SAMPLE_W-1:0] b);
        int                    planes;
        int                    w;
        int                    col;
        int                    last_plane;
        logic [3*SAMPLE_W-1:0] entry;
        logic [15:0]           prod;
        pixel_t                px;
        planes = (mode_reg == MODE_RGB) ? 3 : (mode_reg == MODE_CMYK) ? 4 : 1;
        if (width_reg == 0)
            w = 1;
        else if (int'(width_reg) > MAX_WIDTH)
            w = MAX_WIDTH;
        else
            w = int'(width_reg);
        last_plane = planes - 1;
        col = col_idx;
        if (plane_idx > last_plane)
            plane_idx = 0;
        if (col >= w)
            col = 0;
        entry = plane_store[col];
        if (plane_idx < last_plane)
        begin
            entry[8*plane_idx +: 8] = b;
            plane_store[col] = entry;
        end
        else
        begin
            if (planes == 1)
            begin
                px.red   = b;
                px.green = b;
                px.blue  = b;
            end
            else if (planes == 3)
            begin
                px.red   = entry[7:0];
                px.green = entry[15:8];
                px.blue  = b;
            end
            else
            begin
                prod     = entry[7:0] * b;
                px.red   = prod[15:8];
                prod     = entry[15:8] * b;
                px.green = prod[15:8];
                prod     = entry[23:16] * b;
                px.blue  = prod[15:8];
            end
            px.alpha    = ALPHA_OPAQUE;
            px.col      = col[COL_W-1:0];
            px.row_last = (col == w - 1);
            pixel_q.insert(pixel_q.size(), px);
        end
        // Step to the next column, and to the next plane at the row's end.
        if (col == w - 1)
        begin
            col_idx   = 0;
            plane_idx = (plane_idx == last_plane) ? 0 : plane_idx + 1;
        end
        else
        begin
            col_idx = col + 1;
        end
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t seen;
        pixel_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
                plane_store[i] = '0;
            mode_reg    = MODE_GRAY;
            width_reg   = ROW_WIDTH_W'(1);
            plane_idx   = 0;
            col_idx     = 0;
            pixel_q.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            // Compare the outgoing pixel before queueing new predictions.
            if (out_valid && !out_stall)
            begin
                seen = '{red, green, blue, alpha, pixel_index, row_end};
                if (pixel_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected pixel r=%02h g=%02h b=%02h a=%02h col=%0d end=%0b",
                             $time, seen.red, seen.green, seen.blue, seen.alpha,
                             seen.col, seen.row_last);
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        $display({"%0t: pixel mismatch: expected r=%02h g=%02h b=%02h a=%02h",
                                  " col=%0d end=%0b, got r=%02h g=%02h b=%02h a=%02h",
                                  " col=%0d end=%0b"},
                                 $time, want.red, want.green, want.blue, want.alpha,
                                 want.col, want.row_last, seen.red, seen.green,
                                 seen.blue, seen.alpha, seen.col, seen.row_last);
                    end
                end
            end

            // A write to a real register restarts the row.
            if (cfg_write)
            begin
                if (cfg_index == REG_COLOR_MODE)
                begin
                    mode_reg  = cfg_data[MODE_W-1:0];
                    plane_idx = 0;
                    col_idx   = 0;
                end
                else if (cfg_index == REG_ROW_WIDTH)
                begin
                    width_reg = cfg_data[ROW_WIDTH_W-1:0];
                    plane_idx = 0;
                    col_idx   = 0;
                end
            end

            if (in_valid && !in_stall)
                predict_sample(sample_byte);

            outstanding = pixel_q.size();
        end
    end

endmodule

`default_nettype wire

### tb/planar_row_to_rgba_top_test.sv
`default_nettype none

module planar_row_to_rgba_top_test;
    import prgba_pkg::*;

    // Indexes on the register port that hold no register.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    // Mode code with no layout of its own; the block treats it as grayscale.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int STUCK_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int WIDE_ITEMS   = 200;

    logic                   clk         = 1'b0;
    logic                   rst_n;
    logic                   cfg_write   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_W-1:0]    sample_byte = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [SAMPLE_W-1:0]    red;
    logic [SAMPLE_W-1:0]    green;
    logic [SAMPLE_W-1:0]    blue;
    logic [SAMPLE_W-1:0]    alpha;
    logic [COL_W-1:0]       pixel_index;
    logic                   row_end;

    int fail_count;
    int outstanding;
    int stuck_cycles = 0;

    // Stimulus view of the configuration, used to size rows.
    logic [MODE_W-1:0]      cur_mode  = MODE_GRAY;
    logic [ROW_WIDTH_W-1:0] cur_width = ROW_WIDTH_W'(1);
    bit                     calm      = 1'b0;

    planar_row_to_rgba_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_byte (sample_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .pixel_index (pixel_index),
        .row_end     (row_end)
    );

    rgba_pixel_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_byte (sample_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .pixel_index (pixel_index),
        .row_end     (row_end),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Clock with a period of 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver stalls at random except during calm stretches.
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 38);

    // End the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Sample bytes lean toward the extremes now and then.
    function automatic logic [SAMPLE_W-1:0] pick_byte();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 8'h00;
        else if (k == 1)
            return 8'hFF;
        return SAMPLE_W'($urandom);
    endfunction

    // Items in one complete row under the current settings.
    function automatic int row_items();
        int planes;
        int w;
        planes = (cur_mode == MODE_RGB) ? 3 : (cur_mode == MODE_CMYK) ? 4 : 1;
        if (cur_width == 0)
            w = 1;
        else if (int'(cur_width) > MAX_WIDTH)
            w = MAX_WIDTH;
        else
            w = int'(cur_width);
        return planes * w;
    endfunction

    // Present one item, with random idle cycles ahead of it, and hold it
    // until the block accepts it.
    task automatic send_sample(input logic [SAMPLE_W-1:0] b);
        @(negedge clk);
        while (!calm && ($urandom_range(0, 99) < 38))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        sample_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_sample(pick_byte());
    endtask

    // Write one register on the plain write port.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_COLOR_MODE)
            cur_mode = data[MODE_W-1:0];
        else if (idx == REG_ROW_WIDTH)
            cur_width = data[ROW_WIDTH_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stop sending, wait for every predicted pixel, then let the pipeline
    // finish any store-only items.
    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    // Random mode code, sometimes with junk in the upper data bits.
    task automatic write_random_mode();
        logic [CFG_DATA_W-1:0] data;
        data = '0;
        if ($urandom_range(0, 9) == 0)
            data[MODE_W-1:0] = MODE_SPARE;
        else
            data[MODE_W-1:0] = MODE_W'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0)
            data[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W - MODE_W)'($urandom);
        write_reg(REG_COLOR_MODE, data);
    endtask

    // Random row width, mostly small.
    task automatic write_random_width();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            write_reg(REG_ROW_WIDTH, CFG_DATA_W'(0));
        else if (k <= 4)
            write_reg(REG_ROW_WIDTH, CFG_DATA_W'($urandom_range(9, 48)));
        else
            write_reg(REG_ROW_WIDTH, CFG_DATA_W'($urandom_range(1, 8)));
    endtask

    initial
    begin
        int random_items;
        int phase;
        int len;
        random_items = 0;
        phase        = 0;

        rst_n <= 1'b0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: grayscale, one pixel per row.
        send_sample(8'h00);
        send_sample(8'hFF);

        // Unused mode code and zero width both fall back to the simplest row.
        drain_and_settle();
        write_reg(REG_COLOR_MODE, CFG_DATA_W'(MODE_SPARE));
        write_reg(REG_ROW_WIDTH, CFG_DATA_W'(0));
        send_sample(8'h5A);
        send_sample(8'hA5);

        // RGB with two columns, extremes in the first two planes.
        drain_and_settle();
        write_reg(REG_COLOR_MODE, CFG_DATA_W'(MODE_RGB));
        write_reg(REG_ROW_WIDTH, CFG_DATA_W'(2));
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'h00);
        send_sample(8'h12);
        send_sample(8'hED);

        // CMYK with full and zero key.
        drain_and_settle();
        write_reg(REG_COLOR_MODE, CFG_DATA_W'(MODE_CMYK));
        write_reg(REG_ROW_WIDTH, CFG_DATA_W'(1));
        send_sample(8'hFF);
        send_sample(8'h00);
        send_sample(8'h80);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'h00);

        // A register write drops a partly received row.
        drain_and_settle();
        write_reg(REG_COLOR_MODE, CFG_DATA_W'(MODE_RGB));
        send_sample(8'h33);
        send_sample(8'hCC);
        drain_and_settle();
        write_reg(REG_ROW_WIDTH, CFG_DATA_W'(1));
        send_sample(8'h01);
        send_sample(8'h80);
        send_sample(8'h7F);

        // Oversized width: the start of a grayscale row past the store size.
        drain_and_settle();
        write_reg(REG_COLOR_MODE, CFG_DATA_W'(MODE_GRAY));
        write_reg(REG_ROW_WIDTH, CFG_DATA_W'(8191));
        send_random(WIDE_ITEMS);

        // Random phases: new settings, whole rows, sometimes a broken row.
        while (random_items < RANDOM_ITEMS)
        begin
            drain_and_settle();
            calm = (phase >= 4) && (phase < 8);
            case ($urandom_range(0, 3))
                0: write_random_mode();
                1: write_random_width();
                2:
                begin
                    write_random_mode();
                    write_random_width();
                end
                default:
                begin
                    write_random_width();
                    write_random_mode();
                end
            endcase
            len = row_items() * $urandom_range(1, 4);
            send_random(len);
            random_items += len;

            if (row_items() > 1 && $urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(1, row_items() - 1);
                send_random(len);
                random_items += len;
                // A write to a spare index must not restart the row.
                if ($urandom_range(0, 1) == 0)
                begin
                    drain_and_settle();
                    write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                              CFG_DATA_W'($urandom));
                    len = row_items();
                    send_random(len);
                    random_items += len;
                end
            end
            phase++;
        end

        calm = 1'b0;
        drain_and_settle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
